FILE: hdl/qdar_pkg.sv
// ----------------------------------------------------------------------------
// qdar_pkg
// Shared types and constants for the quaternion delta angular rate unit.
// ----------------------------------------------------------------------------
package qdar_pkg;

    localparam int QW      = 32;             // quaternion component width
    localparam int DTW     = 24;             // elapsed time width
    localparam int PRODW   = 2 * QW;         // one product
    localparam int ACCW    = PRODW + 3;      // sum of four products, signed
    localparam int MAGW    = ACCW;           // magnitude of a sum
    localparam int K_US    = 2000000;        // 2 * microseconds per second
    localparam int KW      = 21;             // bits of K_US
    localparam int SCW     = MAGW + KW;      // scaled magnitude width

    typedef struct packed {
        logic       start;     // begin scaling and division for the selected axis
        logic [1:0] axis;      // which rate is being produced
    } qdar_cmd_t;

    typedef struct packed {
        logic       div_done;  // quotient ready
    } qdar_stat_t;

endpackage

FILE: hdl/qdar_ctrl.sv
// ----------------------------------------------------------------------------
// qdar_ctrl
// Sequencer: products, then one division per axis (none for a zero interval), then output hand-off.
// ----------------------------------------------------------------------------
module qdar_ctrl
    import qdar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       zero_dt,
    input  logic       out_free,
    input  qdar_stat_t stat,
    output logic       busy,
    output logic [3:0] term_idx,
    output logic       term_en,
    output logic       acc_clr,
    output logic       load_out,
    output qdar_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        term_en    = 1'b0;
        acc_clr    = 1'b0;
        load_out   = 1'b0;
        cmd.start  = 1'b0;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    acc_clr    = 1'b1;
                    cnt_next   = 4'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                term_en = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd11)
                begin
                    axis_next  = 2'd0;
                    state_next = zero_dt ? S_OUT : S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (axis_reg == 2'd2)
                        state_next = S_OUT;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIVS;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign term_idx = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg <= 4'd11))
        else $error("term counter overrun");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis out of range");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_DIVW))
        else $error("start not followed by wait");

endmodule

FILE: hdl/qdar_dp.sv
// ----------------------------------------------------------------------------
// qdar_dp
// Datapath: serial multiply-accumulate of the twelve products, a chunked
// scaling by the time constant, then a restoring divider producing one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module qdar_dp
    import qdar_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 30,
    parameter int RATE_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic signed [QW-1:0] cw_in,
    input  logic signed [QW-1:0] cx_in,
    input  logic signed [QW-1:0] cy_in,
    input  logic signed [QW-1:0] cz_in,
    input  logic [DTW-1:0]       dt_in,
    input  logic [3:0]           term_idx,
    input  logic                 term_en,
    input  logic                 acc_clr,
    input  qdar_cmd_t            cmd,
    output qdar_stat_t           stat,
    output logic                 zero_dt,
    output logic signed [QW-1:0] rx,
    output logic signed [QW-1:0] ry,
    output logic signed [QW-1:0] rz,
    output logic                 sat
);

    // numerator = mag * K * 2^RATE >> 2*QUAT; net right shift since 2Q > RATE
    localparam int SHR   = 2 * QUAT_FRAC_BITS - RATE_FRAC_BITS;   // 4..52, >0
    localparam int NUMW  = SCW;                                   // upper bound width
    localparam int QBITS = NUMW;
    localparam int CW    = $clog2(QBITS + 1);
    localparam int CHW   = 23;                                    // scaling chunk
    localparam int NCH   = 3;                                     // chunks per magnitude
    localparam int MPW   = CHW * NCH;                             // padded magnitude
    localparam int PW    = CHW + KW;                              // chunk product
    localparam logic [KW-1:0] K_C = KW'(K_US);

    logic signed [QW-1:0] cw_reg, cx_reg, cy_reg, cz_reg;
    logic signed [QW-1:0] pw_reg, px_reg, py_reg, pz_reg;
    logic [DTW-1:0]       dt_reg;
    logic signed [ACCW-1:0] ax_reg, ay_reg, az_reg;

    // term table: operand a, operand b, subtract, axis
    logic signed [QW-1:0] opa, opb;
    logic                 neg;
    logic [1:0]           tax;
    always_comb
    begin
        opa = pw_reg; opb = cx_reg; neg = 1'b0; tax = 2'd0;
        case (term_idx)
            4'd0:  begin opa = pw_reg; opb = cx_reg; neg = 1'b0; tax = 2'd0; end
            4'd1:  begin opa = cw_reg; opb = px_reg; neg = 1'b1; tax = 2'd0; end
            4'd2:  begin opa = py_reg; opb = cz_reg; neg = 1'b1; tax = 2'd0; end
            4'd3:  begin opa = pz_reg; opb = cy_reg; neg = 1'b0; tax = 2'd0; end
            4'd4:  begin opa = pw_reg; opb = cy_reg; neg = 1'b0; tax = 2'd1; end
            4'd5:  begin opa = cw_reg; opb = py_reg; neg = 1'b1; tax = 2'd1; end
            4'd6:  begin opa = pz_reg; opb = cx_reg; neg = 1'b1; tax = 2'd1; end
            4'd7:  begin opa = px_reg; opb = cz_reg; neg = 1'b0; tax = 2'd1; end
            4'd8:  begin opa = pw_reg; opb = cz_reg; neg = 1'b0; tax = 2'd2; end
            4'd9:  begin opa = cw_reg; opb = pz_reg; neg = 1'b1; tax = 2'd2; end
            4'd10: begin opa = px_reg; opb = cy_reg; neg = 1'b1; tax = 2'd2; end
            4'd11: begin opa = py_reg; opb = cx_reg; neg = 1'b0; tax = 2'd2; end
            default: begin opa = pw_reg; opb = cx_reg; neg = 1'b0; tax = 2'd0; end
        endcase
    end

    logic signed [PRODW-1:0] prod;
    logic signed [ACCW-1:0]  prod_x;
    assign prod   = opa * opb;
    assign prod_x = neg ? -ACCW'(prod) : ACCW'(prod);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cw_reg <= cw_in; cx_reg <= cx_in; cy_reg <= cy_in; cz_reg <= cz_in;
            dt_reg <= dt_in;
        end
        if (acc_clr)
        begin
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
        end
        else if (term_en)
        begin
            case (tax)
                2'd0:    ax_reg <= ax_reg + prod_x;
                2'd1:    ay_reg <= ay_reg + prod_x;
                default: az_reg <= az_reg + prod_x;
            endcase
        end
    end

    // previous quaternion, reset to zero, replaced after the products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= '0; px_reg <= '0; py_reg <= '0; pz_reg <= '0;
        end
        else if (term_en && term_idx == 4'd11)
        begin
            pw_reg <= cw_reg; px_reg <= cx_reg; py_reg <= cy_reg; pz_reg <= cz_reg;
        end
    end

    assign zero_dt = (dt_reg == '0);

    // select the axis sum and take its magnitude
    logic signed [ACCW-1:0] sel;
    logic [MAGW-1:0]        mag;
    always_comb
    begin
        case (cmd.axis)
            2'd0:    sel = ax_reg;
            2'd1:    sel = ay_reg;
            default: sel = az_reg;
        endcase
        mag = sel[ACCW-1] ? MAGW'(-sel) : MAGW'(sel);
    end

    // scaling by K, top chunk first: acc = (acc << CHW) + chunk * K
    logic [MPW-1:0] m_reg;
    logic [SCW-1:0] acc_reg;
    logic [PW-1:0]  part;
    logic [SCW-1:0] acc_nx;
    logic [1:0]     sc_cnt_reg;
    logic           sc_run_reg;
    assign part   = {{KW{1'b0}}, m_reg[MPW-1 -: CHW]} * {{CHW{1'b0}}, K_C};
    assign acc_nx = (acc_reg << CHW) + SCW'(part);

    // restoring divider
    logic [QBITS-1:0] n_reg;
    logic [DTW:0]     r_reg;
    logic [CW-1:0]    k_reg;
    logic             run_reg, neg_reg, done_reg;
    logic [DTW:0]     r_sh;
    logic [DTW:0]     r_sub;
    assign r_sh  = {r_reg[DTW-1:0], n_reg[QBITS-1]};
    assign r_sub = r_sh - {1'b0, dt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            done_reg   <= 1'b0;
            k_reg      <= '0;
            sc_run_reg <= 1'b0;
            sc_cnt_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                sc_run_reg <= 1'b1;
                sc_cnt_reg <= 2'(NCH);
            end
            else if (sc_run_reg)
            begin
                sc_cnt_reg <= sc_cnt_reg - 2'd1;
                if (sc_cnt_reg == 2'd1)
                begin
                    sc_run_reg <= 1'b0;
                    run_reg    <= 1'b1;
                    k_reg      <= CW'(QBITS);
                end
            end
            else if (run_reg)
            begin
                k_reg <= k_reg - CW'(1);
                if (k_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            m_reg   <= MPW'(mag);
            acc_reg <= '0;
            r_reg   <= '0;
            neg_reg <= sel[ACCW-1];
        end
        else if (sc_run_reg)
        begin
            acc_reg <= acc_nx;
            m_reg   <= m_reg << CHW;
            if (sc_cnt_reg == 2'd1)
                n_reg <= acc_nx >> SHR;
        end
        else if (run_reg)
        begin
            if (!r_sub[DTW])
            begin
                r_reg <= r_sub;
                n_reg <= {n_reg[QBITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                n_reg <= {n_reg[QBITS-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = done_reg;

    // saturate and sign the quotient
    logic [QW-1:0] lim;
    logic          over;
    logic [QW-1:0] res;
    assign lim  = neg_reg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign over = (n_reg > QBITS'(lim));
    assign res  = over ? (neg_reg ? lim : lim) : n_reg[QW-1:0];

    logic s0_reg, s1_reg, s2_reg;
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rx <= '0; ry <= '0; rz <= '0;
            s0_reg <= 1'b0; s1_reg <= 1'b0; s2_reg <= 1'b0;
        end
        else if (done_reg)
        begin
            case (cmd.axis)
                2'd0:    begin rx <= neg_reg ? -res : res; s0_reg <= over; end
                2'd1:    begin ry <= neg_reg ? -res : res; s1_reg <= over; end
                default: begin rz <= neg_reg ? -res : res; s2_reg <= over; end
            endcase
        end
    end
    assign sat = s0_reg | s1_reg | s2_reg;

endmodule

FILE: hdl/quaternion_delta_angular_rate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_delta_angular_rate_unit
// Angular rate from two successive orientation quaternions.
// ----------------------------------------------------------------------------
// Each accepted item holds a Q30 quaternion and the microseconds since the
// previous one. The unit forms the vector part of conj(previous) * current
// with one 32x32 multiplier over twelve products, then for each axis scales
// the magnitude by the time constant and divides it by the interval in a
// shared restoring divider that yields one quotient bit per cycle (88 bits).
// With a zero interval the divisions are skipped and the unit reports zero
// rates. Rates are Q16.16 rad/s, truncated toward zero and clamped to 32
// bits, with a flag when clamping happened. The stored quaternion resets to
// zero, so the first item after reset gives zero rates. A result waits in an
// output register; the next item is taken once the unit is idle. One item is
// in work at a time.
module quaternion_delta_angular_rate_unit
    import qdar_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 30,
    parameter int RATE_FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z, elapsed_us
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // rate_x, rate_y, rate_z
    output logic [1:0]   m_tuser    // rate_saturated, zero_interval
);

    logic       busy, in_fire, term_en, acc_clr, load_out, zero_dt, sat;
    logic [3:0] term_idx;
    qdar_cmd_t  cmd;
    qdar_stat_t stat;
    logic signed [QW-1:0] rx, ry, rz;
    logic       valid_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    qdar_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .zero_dt(zero_dt),
        .out_free(!valid_reg || m_tready), .stat(stat), .busy(busy),
        .term_idx(term_idx), .term_en(term_en), .acc_clr(acc_clr),
        .load_out(load_out), .cmd(cmd)
    );

    qdar_dp #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS), .RATE_FRAC_BITS(RATE_FRAC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .cw_in(s_tdata[31:0]), .cx_in(s_tdata[63:32]),
        .cy_in(s_tdata[95:64]), .cz_in(s_tdata[127:96]),
        .dt_in(s_tdata[151:128]), .term_idx(term_idx), .term_en(term_en),
        .acc_clr(acc_clr), .cmd(cmd), .stat(stat), .zero_dt(zero_dt),
        .rx(rx), .ry(ry), .rz(rz), .sat(sat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_out)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata <= zero_dt ? 96'd0 : {rz, ry, rx};
            m_tuser <= {zero_dt, zero_dt ? 1'b0 : sat};
        end
    end

    assign m_tvalid = valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !load_out)
        else $error("result overwritten");
    a_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy)
        else $error("not busy after accept");
    a_zero_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("both flags set");

endmodule
